[rtl/kmpt_pkg.sv]
package kmpt_pkg;

   localparam int REQ_DATA_BITS = 48;
   localparam int RSP_DATA_BITS = 88;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  target_id;
      logic [31:0] amount;
      logic        mark_in;
   } kmpt_item_type;

   typedef struct packed {
      logic [31:0] weight_after;
      logic        mark_after;
      logic [1:0]  status;
      logic        top_valid;
      logic [7:0]  top_target;
      logic [31:0] top_weight;
      logic [6:0]  entry_count;
   } kmpt_rsp_type;

endpackage

[rtl/kmpt_front.sv]
module kmpt_front import kmpt_pkg::*; #(
   parameter int ID_BITS     = 8,
   parameter int WEIGHT_BITS = 32
) (
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [1:0]    command,
   input  logic [7:0]    target_id,
   input  logic [31:0]   amount,
   input  logic          mark_in,
   output logic          push_valid,
   input  logic          push_ready,
   output kmpt_item_type push_item
);

   localparam logic [32:0] AMT_LIMIT = (WEIGHT_BITS >= 32) ? 33'h0_FFFF_FFFF :
                                       ((33'd1 << WEIGHT_BITS) - 33'd1);

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;

   // amount clipped to the weight range, id folded to the id space
   always_comb begin
      push_item.command   = command;
      push_item.target_id = 8'(ID_BITS'(target_id));
      push_item.amount    = ({1'b0, amount} > AMT_LIMIT) ? 32'(AMT_LIMIT) : amount;
      push_item.mark_in   = mark_in;
   end

endmodule

[rtl/kmpt_queue.sv]
module kmpt_queue import kmpt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  kmpt_item_type push_item,
   output logic          pop_valid,
   input  logic          pop_ready,
   output kmpt_item_type pop_item
);

   kmpt_item_type slot_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    fill_ff, fill_in;
   logic          do_push, do_pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      fill_in   = fill_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[rtl/kmpt_engine.sv]
module kmpt_engine import kmpt_pkg::*; #(
   parameter int MAX_ENTRIES = 64,
   parameter int ID_BITS     = 8,
   parameter int WEIGHT_BITS = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          pop_valid,
   output logic          pop_ready,
   input  kmpt_item_type pop_item,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output kmpt_rsp_type  rsp_data
);

   localparam int NUM_IDS = 1 << ID_BITS;
   localparam int CB      = $clog2(MAX_ENTRIES + 1);
   localparam int HB      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam logic [CB-1:0] CNT_MAX = CB'(MAX_ENTRIES);
   localparam logic [WEIGHT_BITS-1:0] W_MAX = '1;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_LOOK    = 4'd1;
   localparam logic [3:0] S_DEC     = 4'd2;
   localparam logic [3:0] S_UP_RD   = 4'd3;
   localparam logic [3:0] S_UP_CMP  = 4'd4;
   localparam logic [3:0] S_DEL_RD  = 4'd5;
   localparam logic [3:0] S_DEL_CMP = 4'd6;
   localparam logic [3:0] S_DN_RD   = 4'd7;
   localparam logic [3:0] S_DN_CMP  = 4'd8;
   localparam logic [3:0] S_PLACE   = 4'd9;
   localparam logic [3:0] S_FIN     = 4'd10;
   localparam logic [3:0] S_RES1    = 4'd11;
   localparam logic [3:0] S_RES2    = 4'd12;

   // heap and position stores
   logic [ID_BITS-1:0]     heap_id_mem [MAX_ENTRIES];
   logic [WEIGHT_BITS-1:0] heap_w_mem  [MAX_ENTRIES];
   logic [CB-1:0]          slot_mem    [NUM_IDS];
   logic [NUM_IDS-1:0]     slot_vld_ff, slot_vld_in;
   logic [NUM_IDS-1:0]     mark_ff, mark_in;

   logic [3:0]             state_ff, state_in;
   logic [1:0]             cmd_ff, cmd_in;
   logic [ID_BITS-1:0]     id_ff, id_in;
   logic [WEIGHT_BITS-1:0] amt_ff, amt_in;
   logic                   mk_ff, mk_in;
   logic [CB-1:0]          count_ff, count_in;
   logic [CB-1:0]          pos_ff, pos_in;
   logic [ID_BITS-1:0]     mov_id_ff, mov_id_in;
   logic [WEIGHT_BITS-1:0] mov_w_ff, mov_w_in;
   logic [1:0]             status_ff, status_in;
   logic                   rv_ff, rv_in;
   logic                   hit_ff, hit_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   kmpt_rsp_type           rsp_data_ff, rsp_data_in;

   // memory ports
   logic                   rda_en, rdb_en, hw_en, sw_en, s_rd_en;
   logic [HB-1:0]          rda_addr, rdb_addr, hw_addr;
   logic [ID_BITS-1:0]     hw_id, sw_addr, s_rd_addr;
   logic [WEIGHT_BITS-1:0] hw_w;
   logic [CB-1:0]          sw_data;
   logic [ID_BITS-1:0]     rda_id_ff, rdb_id_ff;
   logic [WEIGHT_BITS-1:0] rda_w_ff, rdb_w_ff;
   logic [CB-1:0]          s_rd_ff;
   logic                   s_rd_vld_ff;

   logic [CB-1:0]          s_look;
   logic [CB:0]            left;
   logic [WEIGHT_BITS:0]   sum;
   logic                   out_free;

   assign pop_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s_look    = s_rd_vld_ff ? s_rd_ff : '0;
   assign left      = {pos_ff, 1'b0};
   assign sum       = {1'b0, rda_w_ff} + {1'b0, amt_ff};

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      id_in        = id_ff;
      amt_in       = amt_ff;
      mk_in        = mk_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      mov_id_in    = mov_id_ff;
      mov_w_in     = mov_w_ff;
      status_in    = status_ff;
      rv_in        = rv_ff;
      hit_in       = hit_ff;
      slot_vld_in  = slot_vld_ff;
      mark_in      = mark_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      rda_en       = 1'b0;
      rdb_en       = 1'b0;
      rda_addr     = '0;
      rdb_addr     = '0;
      hw_en        = 1'b0;
      hw_addr      = HB'(pos_ff - 1'b1);
      hw_id        = mov_id_ff;
      hw_w         = mov_w_ff;
      sw_en        = 1'b0;
      sw_addr      = mov_id_ff;
      sw_data      = pos_ff;
      s_rd_en      = 1'b0;
      s_rd_addr    = id_ff;

      case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               cmd_in    = pop_item.command;
               id_in     = ID_BITS'(pop_item.target_id);
               amt_in    = WEIGHT_BITS'(pop_item.amount);
               mk_in     = pop_item.mark_in;
               status_in = ST_OK;
               s_rd_en   = 1'b1;
               s_rd_addr = ID_BITS'(pop_item.target_id);
               state_in  = S_LOOK;
            end
         end
         S_LOOK: begin
            pos_in   = s_look;
            rda_en   = (s_look != '0);
            rda_addr = HB'(s_look - 1'b1);
            rdb_en   = (count_ff != '0);
            rdb_addr = HB'(count_ff - 1'b1);
            state_in = S_DEC;
         end
         S_DEC: begin
            state_in = S_FIN;
            case (cmd_ff)
               CMD_ADD: begin
                  mov_id_in = id_ff;
                  if (pos_ff == '0) begin
                     if (count_ff >= CNT_MAX) begin
                        status_in = ST_FULL;
                     end else begin
                        count_in       = count_ff + 1'b1;
                        pos_in         = count_ff + 1'b1;
                        mov_w_in       = amt_ff;
                        mark_in[id_ff] = mk_ff;
                        state_in       = S_UP_RD;
                     end
                  end else begin
                     mov_w_in = sum[WEIGHT_BITS] ? W_MAX : sum[WEIGHT_BITS-1:0];
                     if (mk_ff) begin
                        mark_in[id_ff] = 1'b1;
                     end
                     state_in = S_UP_RD;
                  end
               end
               CMD_REMOVE: begin
                  if (pos_ff == '0) begin
                     status_in = ST_NOTFOUND;
                  end else if (amt_ff < rda_w_ff) begin
                     mov_id_in      = id_ff;
                     mov_w_in       = rda_w_ff - amt_ff;
                     mark_in[id_ff] = mk_ff;
                     state_in       = S_DN_RD;
                  end else begin
                     slot_vld_in[id_ff] = 1'b0;
                     mark_in[id_ff]     = 1'b0;
                     count_in           = count_ff - 1'b1;
                     if (pos_ff != count_ff) begin
                        mov_id_in = rdb_id_ff;
                        mov_w_in  = rdb_w_ff;
                        state_in  = S_DEL_RD;
                     end
                  end
               end
               CMD_CLEAR: begin
                  mark_in = '0;
               end
               default: begin
               end
            endcase
         end
         S_UP_RD: begin
            if (pos_ff == CB'(1)) begin
               state_in = S_PLACE;
            end else begin
               rda_en   = 1'b1;
               rda_addr = HB'((pos_ff >> 1) - 1'b1);
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (rda_w_ff < mov_w_ff) begin
               hw_en    = 1'b1;
               hw_id    = rda_id_ff;
               hw_w     = rda_w_ff;
               sw_en    = 1'b1;
               sw_addr  = rda_id_ff;
               pos_in   = pos_ff >> 1;
               state_in = S_UP_RD;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_DEL_RD: begin
            if (pos_ff == CB'(1)) begin
               state_in = S_DN_RD;
            end else begin
               rda_en   = 1'b1;
               rda_addr = HB'((pos_ff >> 1) - 1'b1);
               state_in = S_DEL_CMP;
            end
         end
         S_DEL_CMP: begin
            state_in = (rda_w_ff < mov_w_ff) ? S_UP_CMP : S_DN_RD;
         end
         S_DN_RD: begin
            if (left > {1'b0, count_ff}) begin
               state_in = S_PLACE;
            end else begin
               rda_en   = 1'b1;
               rda_addr = HB'(left - 1'b1);
               rv_in    = (left < {1'b0, count_ff});
               rdb_en   = rv_in;
               rdb_addr = HB'(left);
               state_in = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            if (rv_ff && (rdb_w_ff > rda_w_ff)) begin
               if (rdb_w_ff > mov_w_ff) begin
                  hw_en    = 1'b1;
                  hw_id    = rdb_id_ff;
                  hw_w     = rdb_w_ff;
                  sw_en    = 1'b1;
                  sw_addr  = rdb_id_ff;
                  pos_in   = CB'(left + 1'b1);
                  state_in = S_DN_RD;
               end else begin
                  state_in = S_PLACE;
               end
            end else if (rda_w_ff > mov_w_ff) begin
               hw_en    = 1'b1;
               hw_id    = rda_id_ff;
               hw_w     = rda_w_ff;
               sw_en    = 1'b1;
               sw_addr  = rda_id_ff;
               pos_in   = CB'(left);
               state_in = S_DN_RD;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            hw_en                  = 1'b1;
            sw_en                  = 1'b1;
            slot_vld_in[mov_id_ff] = 1'b1;
            state_in               = S_FIN;
         end
         S_FIN: begin
            rda_en   = 1'b1;
            rda_addr = '0;
            s_rd_en  = 1'b1;
            state_in = S_RES1;
         end
         S_RES1: begin
            hit_in   = (s_look != '0);
            rdb_en   = hit_in;
            rdb_addr = HB'(s_look - 1'b1);
            state_in = S_RES2;
         end
         S_RES2: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.weight_after = hit_ff ? 32'(rdb_w_ff) : 32'd0;
               rsp_data_in.mark_after   = hit_ff & mark_ff[id_ff];
               rsp_data_in.status       = status_ff;
               rsp_data_in.top_valid    = (count_ff != '0);
               rsp_data_in.top_target   = (count_ff != '0) ? 8'(rda_id_ff) : 8'd0;
               rsp_data_in.top_weight   = (count_ff != '0) ? 32'(rda_w_ff) : 32'd0;
               rsp_data_in.entry_count  = 7'(count_ff);
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         slot_vld_ff  <= '0;
         mark_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         slot_vld_ff  <= slot_vld_in;
         mark_ff      <= mark_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      id_ff       <= id_in;
      amt_ff      <= amt_in;
      mk_ff       <= mk_in;
      pos_ff      <= pos_in;
      mov_id_ff   <= mov_id_in;
      mov_w_ff    <= mov_w_in;
      status_ff   <= status_in;
      rv_ff       <= rv_in;
      hit_ff      <= hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (hw_en) begin
         heap_id_mem[hw_addr] <= hw_id;
         heap_w_mem[hw_addr]  <= hw_w;
      end
      if (rda_en) begin
         rda_id_ff <= heap_id_mem[rda_addr];
         rda_w_ff  <= heap_w_mem[rda_addr];
      end
      if (rdb_en) begin
         rdb_id_ff <= heap_id_mem[rdb_addr];
         rdb_w_ff  <= heap_w_mem[rdb_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (sw_en) begin
         slot_mem[sw_addr] <= sw_data;
      end
      if (s_rd_en) begin
         s_rd_ff     <= slot_mem[s_rd_addr];
         s_rd_vld_ff <= slot_vld_ff[s_rd_addr];
      end
   end

endmodule

[rtl/keyed_max_priority_table.sv]
// Keyed max-priority table: each id holds a weight and a mark in a binary
// max-heap with a per-id position store. One response per request. A request
// that walks the heap by sift-up or sift-down spends a read state and a compare
// state on each heap level walked; the heap memory's single write port and
// registered reads set this per-level cost. A two-deep queue sits between the
// input decode and the heap sequencer, and a response register lets new
// requests queue while a response waits.
module keyed_max_priority_table import kmpt_pkg::*; #(
   parameter int MAX_ENTRIES = 64,
   parameter int ID_BITS     = 8,
   parameter int WEIGHT_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // target_id, amount, mark_in
   input  logic [1:0]               req_tuser,  // command
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // weight_after, mark_after, top_valid, top_target, top_weight, entry_count
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic [1:0]               rsp_tuser   // status
);

   logic          push_valid, push_ready, pop_valid, pop_ready;
   kmpt_item_type push_item, pop_item;
   kmpt_rsp_type  rsp;

   kmpt_front #(
      .ID_BITS(ID_BITS),
      .WEIGHT_BITS(WEIGHT_BITS)
   ) u_front (
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .command(req_tuser),
      .target_id(req_tdata[7:0]),
      .amount(req_tdata[39:8]),
      .mark_in(req_tdata[40]),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_item(push_item)
   );

   kmpt_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_item(push_item),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_item(pop_item)
   );

   kmpt_engine #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .ID_BITS(ID_BITS),
      .WEIGHT_BITS(WEIGHT_BITS)
   ) u_engine (
      .clock(clock),
      .reset(reset),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_item(pop_item),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .rsp_data(rsp)
   );

   assign rsp_tdata = {7'd0, rsp.entry_count, rsp.top_weight, rsp.top_target, rsp.top_valid,
                       rsp.mark_after, rsp.weight_after};
   assign rsp_tuser = rsp.status;

endmodule
